// ===== rtl/core/lksc_pkg.sv =====
// lksc_pkg: constants shared by the keystream byte cipher unit.
// Generator multiplier and increment, field masks and range mask.
// No dependencies.
`default_nettype none

package lksc_pkg;

	localparam logic [31:0] LcgMul     = 32'h41c6_4e6d;
	localparam logic [31:0] LcgAdd     = 32'h0000_3039;
	localparam logic [31:0] FieldAMask = 32'hffe0_0000;
	localparam logic [31:0] FieldBMask = 32'hfffc_0000;
	localparam logic [30:0] RMask      = 31'h7fff_ffff;

endpackage : lksc_pkg

`default_nettype wire

// ===== rtl/core/lksc_lcg_step.sv =====
// lksc_lcg_step: one generator step, state * multiplier + increment mod 2^32.
// Shared unit used three times per byte by the top level sequencer.
// Depends on lksc_pkg.
`default_nettype none

module lksc_lcg_step (
	input  wire  logic [31:0] cur_state,
	output logic       [31:0] next_state
);

	logic [31:0] product;

	assign product    = cur_state * lksc_pkg::LcgMul;
	assign next_state = product + lksc_pkg::LcgAdd;

endmodule : lksc_lcg_step

`default_nettype wire

// ===== rtl/core/lksc_scale.sv =====
// lksc_scale: maps the 31-bit draw r to the low byte of floor(r*255/(2^31-1)) + 1.
// Divides by 2^31-1 with one fold: m = hi*2^31 + lo, q = hi + (hi+lo >= 2^31-1).
// Depends on lksc_pkg.
`default_nettype none

module lksc_scale (
	input  wire  logic [30:0] draw,
	output logic       [7:0]  key_stream
);

	logic [38:0] scaled;
	logic [7:0]  hi;
	logic [31:0] folded;
	logic        carry;

	assign scaled     = {draw, 8'h00} - {8'h00, draw};
	assign hi         = scaled[38:31];
	assign folded     = {1'b0, scaled[30:0]} + {24'h000000, hi};
	assign carry      = (folded >= {1'b0, lksc_pkg::RMask});
	assign key_stream = hi + {7'h00, carry} + 8'h01;

endmodule : lksc_scale

`default_nettype wire

// ===== rtl/core/lcg_keystream_byte_cipher_unit.sv =====
// lcg_keystream_byte_cipher_unit: byte scrambler keyed by a one-byte seed.
// Sequencer around lksc_lcg_step (shared mul-add) and lksc_scale (output map).
// Depends on lksc_pkg, lksc_lcg_step, lksc_scale.
//
// channel   handshake            payload
// in        in_valid / in_stall  data_byte[7:0], first_of_message
// out       out_valid / out_stall out_byte[7:0]
// cfg       cfg_valid / cfg_ready cfg_data[7:0] (key_byte)
//
// A byte passes through the accept cycle, three generator steps through the single
// shared 32x32 multiplier, then the scale and xor into the output register in S_FINISH.
// The result beat becomes valid when S_FINISH writes the output register. No new byte is
// taken until the last has left S_FINISH; the output register holds one finished beat, so
// out_stall blocks intake only once a second result is ready.
// Reset clears the generator, the key and all control state.
`default_nettype none

module lcg_keystream_byte_cipher_unit (
	input  wire  logic       clk,
	input  wire  logic       arst_n,
	input  wire  logic       in_valid,
	output logic             in_stall,
	input  wire  logic [7:0] data_byte,
	input  wire  logic       first_of_message,
	output logic             out_valid,
	input  wire  logic       out_stall,
	output logic       [7:0] out_byte,
	input  wire  logic       cfg_valid,
	output logic             cfg_ready,
	input  wire  logic [7:0] cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		STEP_A,
		STEP_B,
		STEP_C
	} step_t;

	state_t      state_q;
	step_t       step_q;
	logic [7:0]  key_q;
	logic [31:0] gen_q;
	logic [31:0] cur_q;
	logic [31:0] acc_q;
	logic [7:0]  data_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;

	logic [31:0] next_state;
	logic [7:0]  key_stream;
	logic        out_free;

	lksc_lcg_step u_step (
		.cur_state  (cur_q),
		.next_state (next_state)
	);

	lksc_scale u_scale (
		.draw       (acc_q[30:0]),
		.key_stream (key_stream)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_A;
			key_q       <= 8'h00;
			gen_q       <= 32'h0000_0000;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				key_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_q   <= first_of_message ? {24'h000000, key_q} : gen_q;
						data_q  <= data_byte;
						step_q  <= STEP_A;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					cur_q <= next_state;
					case (step_q)
						STEP_A: begin
							acc_q  <= next_state & lksc_pkg::FieldAMask;
							step_q <= STEP_B;
						end
						STEP_B: begin
							acc_q  <= acc_q + ((next_state & lksc_pkg::FieldBMask) >> 11);
							step_q <= STEP_C;
						end
						STEP_C: begin
							acc_q   <= (acc_q + (next_state >> 25)) & {1'b0, lksc_pkg::RMask};
							gen_q   <= next_state;
							state_q <= S_FINISH;
						end
						default: begin
							step_q <= STEP_A;
						end
					endcase
				end
				S_FINISH: begin
					if (out_free) begin
						out_byte_q  <= data_q ^ key_stream;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule : lcg_keystream_byte_cipher_unit

`default_nettype wire
